@@ hdl/prds_pkg.sv @@
`timescale 1ns / 1ps
package prds_pkg;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  domain;
    logic [31:0] now;
  } prds_req_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  event_domain;
    logic [1:0]  event_code;
    logic [2:0]  status;
    logic        ready_res;
    logic [15:0] settle_left;
    logic [1:0]  domain_mode;
    logic [17:0] load_ma;
    logic        all_off;
    logic [3:0]  rails_on;
    logic        last;
  } prds_res_t;

  localparam logic [2:0] CMD_ACQUIRE = 3'd0;
  localparam logic [2:0] CMD_RELEASE = 3'd1;
  localparam logic [2:0] CMD_ARM     = 3'd2;
  localparam logic [2:0] CMD_DISARM  = 3'd3;
  localparam logic [2:0] CMD_TICK    = 3'd4;
  localparam logic [2:0] CMD_QUERY   = 3'd5;

  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_SETTLING = 2'd1;
  localparam logic [1:0] MODE_ON       = 2'd2;

  localparam logic [1:0] POL_PER_READ = 2'd0;
  localparam logic [1:0] POL_HOLD     = 2'd1;
  localparam logic [1:0] POL_PERIODIC = 2'd2;
  localparam logic [1:0] POL_ARMED    = 2'd3;

  localparam logic [1:0] EV_READY    = 2'd0;
  localparam logic [1:0] EV_OFF      = 2'd1;
  localparam logic [1:0] EV_DEFERRED = 2'd2;
  localparam logic [1:0] EV_TIMEOUT  = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_INVALID     = 3'd1;
  localparam logic [2:0] ST_BUSY        = 3'd2;
  localparam logic [2:0] ST_AGAIN       = 3'd3;
  localparam logic [2:0] ST_ACCESS      = 3'd4;
  localparam logic [2:0] ST_OVERFLOW    = 3'd5;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd6;

  localparam logic [2:0] REG_BUDGET  = 3'd0;
  localparam logic [2:0] REG_POLICY  = 3'd1;
  localparam logic [2:0] REG_CURRENT = 3'd2;
  localparam logic [2:0] REG_SETTLE  = 3'd3;
  localparam logic [2:0] REG_ON      = 3'd4;
  localparam logic [2:0] REG_PERIOD  = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic       load_req;   // capture request, clear domain pointer
    logic       do_cmd;     // execute addressed command
    logic       do_tick;    // execute tick step for pointed domain
    logic       next_dom;   // advance domain pointer
    logic       do_reply;   // emit final status
  } prds_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic last_dom;
    logic ev_pend;    // events still draining, hold the sequence
  } prds_sts_t;

endpackage

@@ hdl/power_rail_domain_sequencer.sv @@
`timescale 1ns / 1ps
// Power rail domain sequencer.
// Request channel: cmd, domain and now in req; a request is taken when start
// is high and busy is low. Busy stays high until the final status item.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, write only while busy is low.
// Result channel: res_valid marks one item for exactly one cycle; the
// receiver cannot stall, so no backpressure exists. Events come first, the
// item with last set is the final status reply.
// Sequence: a domain command executes in the dispatch state and then its
// events drain before the reply state; a tick passes the dispatch state,
// then walks the domains one at a time in the tick state, each step's
// events draining before the next, then the reply state. The sequential
// walk over domains shares one update unit and one event drain path. The
// next request is taken once busy falls after the reply; a tick step emits
// at most three events per domain.
// Reset (rst, synchronous): all rails off, counts and flags clear, windows
// due, configuration registers zero.
module power_rail_domain_sequencer
  import prds_pkg::*;
#(
  parameter int NUM_DOMAINS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  prds_req_t   req,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        res_valid,
  output prds_res_t   res
);

  prds_ctl_t ctl;
  prds_sts_t sts;

  assign cfg_ready = 1'b1;

  prds_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sts(sts), .ctl(ctl)
  );

  prds_dpath #(.NUM_DOMAINS(NUM_DOMAINS)) u_dpath (
    .clk(clk), .rst(rst), .req(req), .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .ctl(ctl), .sts(sts),
    .res_valid(res_valid), .res(res)
  );

  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.kind == res.last)) else $error("kind and last differ");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !res_valid) else $error("result while idle");
  a_reply_ends: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.last) |=> !busy) else $error("busy after reply");

endmodule

@@ hdl/prds_ctrl.sv @@
`timescale 1ns / 1ps
module prds_ctrl
  import prds_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  prds_sts_t sts,
  output prds_ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DISP  = 4'b0010,
    S_TICK  = 4'b0100,
    S_REPLY = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    if (!sts.ev_pend) begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ctl.load_req = 1'b1;
            state_next = S_DISP;
          end
        end
        S_DISP: begin
          if (sts.is_tick) begin
            state_next = S_TICK;
          end else begin
            ctl.do_cmd = 1'b1;
            state_next = S_REPLY;
          end
        end
        S_TICK: begin
          ctl.do_tick = 1'b1;
          ctl.next_dom = 1'b1;
          if (sts.last_dom) state_next = S_REPLY;
        end
        S_REPLY: begin
          ctl.do_reply = 1'b1;
          state_next = S_IDLE;
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule

@@ hdl/prds_dpath.sv @@
`timescale 1ns / 1ps
module prds_dpath
  import prds_pkg::*;
#(
  parameter int NUM_DOMAINS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  prds_req_t   req,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  prds_ctl_t   ctl,
  output prds_sts_t   sts,
  output logic        res_valid,
  output prds_res_t   res
);

  logic [15:0] budget_lim;
  logic [7:0]  policy_codes;
  logic [63:0] current_table, settle_table, on_table, period_table;

  logic [1:0]  rail_mode      [4];
  logic [7:0]  ref_count      [4];
  logic        arm_flag       [4];
  logic        window_pending [4];
  logic [31:0] on_stamp       [4];
  logic [31:0] window_stamp   [4];

  prds_req_t r;
  logic [1:0] ptr;

  // pending event queue of four entries, at most three per step
  logic [1:0] ev_code [4];
  logic [2:0] ev_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget_lim <= '0; policy_codes <= '0;
      current_table <= '0; settle_table <= '0; on_table <= '0; period_table <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BUDGET:  budget_lim <= cfg_data[15:0];
        REG_POLICY:  policy_codes <= cfg_data[7:0];
        REG_CURRENT: current_table <= cfg_data;
        REG_SETTLE:  settle_table <= cfg_data;
        REG_ON:      on_table <= cfg_data;
        REG_PERIOD:  period_table <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [15:0] lane(input logic [63:0] t, input logic [1:0] d);
    return t[d*16 +: 16];
  endfunction

  logic [17:0] load_cur;
  logic [3:0]  rails_cur;
  always_comb begin
    load_cur = '0;
    rails_cur = '0;
    for (int d = 0; d < 4; d++) begin
      if (d < NUM_DOMAINS && rail_mode[d] != MODE_OFF) begin
        load_cur = load_cur + 18'(lane(current_table, 2'(d)));
        rails_cur[d] = 1'b1;
      end
    end
  end

  // working domain: pointer during tick, addressed domain otherwise
  logic [1:0]  d;
  logic [1:0]  pol;
  logic [1:0]  m;
  logic [31:0] on_el, win_el;
  logic [15:0] cur_d, set_d, on_d, per_d;
  logic        fits;
  always_comb begin
    d = ctl.do_tick ? ptr : r.domain[1:0];
    pol = policy_codes[d*2 +: 2];
    m = rail_mode[d];
    on_el = r.now - on_stamp[d];
    win_el = r.now - window_stamp[d];
    cur_d = lane(current_table, d);
    set_d = lane(settle_table, d);
    on_d = lane(on_table, d);
    per_d = lane(period_table, d);
    fits = (budget_lim == 16'd0) || ((load_cur + 18'(cur_d)) <= 18'(budget_lim));
  end

  logic        valid_dom;
  assign valid_dom = (32'(r.domain) < NUM_DOMAINS);
  assign sts.is_tick = (r.cmd == CMD_TICK);
  assign sts.last_dom = (32'(ptr) == NUM_DOMAINS - 1);

  // emission state: events drain one per cycle from the queue snapshot
  logic [2:0]  st_reply;
  logic [17:0] snap_load [4];
  logic [3:0]  snap_rails [4];
  logic [2:0]  ev_dom;
  logic [2:0]  ev_rd;

  logic [1:0]  n_mode;
  logic [7:0]  n_ref;
  logic        n_arm, n_win;
  logic [31:0] n_on, n_wst;
  logic [2:0]  n_status;
  logic [1:0]  q_code [4];
  logic [17:0] q_load [4];
  logic [3:0]  q_rails [4];
  logic [2:0]  q_n;
  logic [17:0] ld;
  logic [3:0]  rl;
  logic [1:0]  mode_w;

  always_comb begin
    n_mode = m; n_ref = ref_count[d]; n_arm = arm_flag[d]; n_win = window_pending[d];
    n_on = on_stamp[d]; n_wst = window_stamp[d]; n_status = ST_OK;
    q_n = '0; ld = load_cur; rl = rails_cur; mode_w = m;
    for (int i = 0; i < 4; i++) begin
      q_code[i] = EV_READY; q_load[i] = '0; q_rails[i] = '0;
    end
    if (ctl.do_tick) begin
      if (mode_w == MODE_SETTLING && on_el >= 32'(set_d)) begin
        n_mode = MODE_ON; mode_w = MODE_ON;
        q_code[q_n[1:0]] = EV_READY; q_load[q_n[1:0]] = ld; q_rails[q_n[1:0]] = rl;
        q_n = q_n + 3'd1;
      end
      if (pol == POL_PERIODIC) begin
        if (mode_w == MODE_OFF) begin
          if (!n_win && win_el >= 32'(per_d)) n_win = 1'b1;
          if (n_win) begin
            if (fits) begin
              n_win = 1'b0; n_wst = r.now; n_on = r.now;
              ld = load_cur + 18'(cur_d); rl[d] = 1'b1;
              if (set_d != 16'd0) n_mode = MODE_SETTLING;
              else begin
                n_mode = MODE_ON;
                q_code[q_n[1:0]] = EV_READY; q_load[q_n[1:0]] = ld;
                q_rails[q_n[1:0]] = rl; q_n = q_n + 3'd1;
              end
            end else begin
              q_code[q_n[1:0]] = EV_DEFERRED; q_load[q_n[1:0]] = ld;
              q_rails[q_n[1:0]] = rl; q_n = q_n + 3'd1;
            end
          end
        end else if (on_el >= 32'(on_d)) begin
          n_mode = MODE_OFF; n_ref = '0;
          ld = load_cur - 18'(cur_d); rl[d] = 1'b0;
          q_code[q_n[1:0]] = EV_OFF; q_load[q_n[1:0]] = ld;
          q_rails[q_n[1:0]] = rl; q_n = q_n + 3'd1;
        end
      end else if (on_d != 16'd0 && mode_w != MODE_OFF && on_el >= 32'(on_d)) begin
        q_code[q_n[1:0]] = EV_TIMEOUT; q_load[q_n[1:0]] = ld;
        q_rails[q_n[1:0]] = rl; q_n = q_n + 3'd1;
        n_mode = MODE_OFF; n_ref = '0;
        ld = load_cur - 18'(cur_d); rl[d] = 1'b0;
        q_code[q_n[1:0]] = EV_OFF; q_load[q_n[1:0]] = ld;
        q_rails[q_n[1:0]] = rl; q_n = q_n + 3'd1;
      end
    end else if (ctl.do_cmd) begin
      if (r.cmd > CMD_QUERY) n_status = ST_UNSUPPORTED;
      else if (!valid_dom) n_status = ST_INVALID;
      else begin
        unique case (r.cmd)
          CMD_ACQUIRE: begin
            priority if ((pol == POL_PER_READ || pol == POL_HOLD) && m == MODE_OFF
                         && !fits) begin
              n_status = ST_BUSY;
            end else if (pol == POL_PERIODIC && m == MODE_OFF) begin
              n_status = ST_AGAIN;
            end else if (pol == POL_ARMED && (!arm_flag[d] || m == MODE_OFF)) begin
              n_status = ST_ACCESS;
            end else begin
              if ((pol == POL_PER_READ || pol == POL_HOLD) && m == MODE_OFF) begin
                n_on = r.now; ld = load_cur + 18'(cur_d); rl[d] = 1'b1;
                if (set_d != 16'd0) n_mode = MODE_SETTLING;
                else begin
                  n_mode = MODE_ON;
                  q_code[0] = EV_READY; q_load[0] = ld; q_rails[0] = rl; q_n = 3'd1;
                end
              end
              if (ref_count[d] == 8'hFF) n_status = ST_OVERFLOW;
              else n_ref = ref_count[d] + 8'd1;
            end
          end
          CMD_RELEASE: begin
            if (ref_count[d] == 8'd0) n_status = ST_INVALID;
            else begin
              n_ref = ref_count[d] - 8'd1;
              if (n_ref == 8'd0 && pol == POL_PER_READ && m != MODE_OFF) begin
                n_mode = MODE_OFF;
                ld = load_cur - 18'(cur_d); rl[d] = 1'b0;
                q_code[0] = EV_OFF; q_load[0] = ld; q_rails[0] = rl; q_n = 3'd1;
              end
            end
          end
          CMD_ARM: begin
            if (pol != POL_ARMED) n_status = ST_UNSUPPORTED;
            else begin
              n_arm = 1'b1;
              if (m == MODE_OFF) begin
                if (!fits) n_status = ST_BUSY;
                else begin
                  n_on = r.now; ld = load_cur + 18'(cur_d); rl[d] = 1'b1;
                  if (set_d != 16'd0) n_mode = MODE_SETTLING;
                  else begin
                    n_mode = MODE_ON;
                    q_code[0] = EV_READY; q_load[0] = ld; q_rails[0] = rl; q_n = 3'd1;
                  end
                end
              end
            end
          end
          CMD_DISARM: begin
            if (pol != POL_ARMED) n_status = ST_UNSUPPORTED;
            else begin
              n_arm = 1'b0;
              if (m != MODE_OFF) begin
                n_mode = MODE_OFF; n_ref = '0;
                ld = load_cur - 18'(cur_d); rl[d] = 1'b0;
                q_code[0] = EV_OFF; q_load[0] = ld; q_rails[0] = rl; q_n = 3'd1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  logic write_state;
  assign write_state = ctl.do_tick || (ctl.do_cmd && valid_dom && r.cmd <= CMD_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        rail_mode[i] <= MODE_OFF; ref_count[i] <= '0; arm_flag[i] <= 1'b0;
        window_pending[i] <= 1'b1; on_stamp[i] <= '0; window_stamp[i] <= '0;
      end
      ptr <= '0; ev_cnt <= '0; ev_rd <= '0; st_reply <= ST_OK;
    end else begin
      if (ctl.load_req) begin
        r <= req; ptr <= '0; st_reply <= ST_OK;
      end
      if (ctl.next_dom) ptr <= ptr + 2'd1;
      if (write_state) begin
        rail_mode[d] <= n_mode; ref_count[d] <= n_ref; arm_flag[d] <= n_arm;
        window_pending[d] <= n_win; on_stamp[d] <= n_on; window_stamp[d] <= n_wst;
      end
      if (ctl.do_cmd) st_reply <= n_status;
      if (ctl.do_tick || ctl.do_cmd) begin
        ev_cnt <= q_n; ev_rd <= '0; ev_dom <= {1'b0, d};
        for (int i = 0; i < 4; i++) begin
          ev_code[i] <= q_code[i]; snap_load[i] <= q_load[i]; snap_rails[i] <= q_rails[i];
        end
      end else if (ev_rd != ev_cnt) begin
        ev_rd <= ev_rd + 3'd1;
      end
    end
  end

  // events from a step go out over following cycles; the controller holds
  // until the queue drains
  logic ev_out;
  assign ev_out = (ev_rd != ev_cnt);
  assign sts.ev_pend = ev_out;

  logic [31:0] q_el;
  logic [15:0] q_st;
  always_comb begin
    q_el = r.now - on_stamp[r.domain[1:0]];
    q_st = lane(settle_table, r.domain[1:0]);
    res = '0;
    res_valid = 1'b0;
    if (ev_out) begin
      res_valid = 1'b1;
      res.event_domain = ev_dom;
      res.event_code = ev_code[ev_rd[1:0]];
      res.load_ma = snap_load[ev_rd[1:0]];
      res.rails_on = snap_rails[ev_rd[1:0]];
      res.all_off = (snap_rails[ev_rd[1:0]] == 4'd0);
    end else if (ctl.do_reply) begin
      res_valid = 1'b1;
      res.kind = 1'b1;
      res.last = 1'b1;
      res.event_domain = r.domain;
      res.status = st_reply;
      res.load_ma = load_cur;
      res.rails_on = rails_cur;
      res.all_off = (rails_cur == 4'd0);
      if (valid_dom) begin
        res.domain_mode = rail_mode[r.domain[1:0]];
        if (rail_mode[r.domain[1:0]] == MODE_ON) res.ready_res = 1'b1;
        else if (rail_mode[r.domain[1:0]] == MODE_SETTLING) begin
          res.ready_res = (q_el >= 32'(q_st));
          res.settle_left = (q_el >= 32'(q_st)) ? 16'd0 : 16'(32'(q_st) - q_el);
        end
      end
    end
  end

endmodule
